// ----- hdl/fqdm_pkg.sv -----
// ----------------------------------------------------------------------------
// fqdm_pkg
// Shared sizes, codes and controller/datapath interface types for the
// delete-capable FIFO queue with running maximum.
// ----------------------------------------------------------------------------
package fqdm_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 2;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, decide status
        logic push_wr;     // write tail, bump count
        logic rd_removed;  // read the element being removed
        logic cap_removed; // latch removed value
        logic shift_rd;    // read entry ptr+1
        logic shift_wr;    // write it back at ptr, advance ptr
        logic dec_fill;    // drop count after removal
        logic scan_start;  // reset maximum scan
        logic scan_rd;     // read next entry for maximum scan
        logic out_load;    // load result registers
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic push_ok;
        logic rem_ok;
        logic shift_more;
        logic scan_more;
    } dp_stat_t;

endpackage

// ----- hdl/fqdm_datapath.sv -----
// ----------------------------------------------------------------------------
// fqdm_datapath
// Queue store, count, request registers, gap-closing shift, maximum scan
// and result registers.
// ----------------------------------------------------------------------------
module fqdm_datapath
    import fqdm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_stat_t                  stat,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [DATA_W-1:0]  push_value,
    input  logic [POS_W-1:0]          position,
    output logic [STAT_W-1:0]         status,
    output logic signed [DATA_W-1:0]  out_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic signed [DATA_W-1:0]  max_value
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [ACT_W-1:0]         act_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [STAT_W-1:0]        req_status_reg;
    logic                     push_ok_reg;
    logic                     rem_ok_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [ADDR_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]         scan_ptr_reg;
    logic                     scan_pv_reg;
    logic                     first_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] rdata_reg;

    logic [STAT_W-1:0]        status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]       entry_count_reg;
    logic signed [DATA_W-1:0] max_out_reg;

    logic [STAT_W-1:0]        req_status;
    logic                     push_ok;
    logic                     rem_ok;
    logic [ADDR_W-1:0]        rm_idx;
    logic [ADDR_W-1:0]        raddr;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     we;

    // request decode against the current count
    always_comb
    begin
        req_status = ST_OK;
        push_ok    = 1'b0;
        rem_ok     = 1'b0;
        case (action)
            ACT_PUSH:
            begin
                if (fill_reg >= CNT_W'(DEPTH))
                    req_status = ST_FULL;
                else
                    push_ok = 1'b1;
            end
            ACT_POP:
            begin
                if (fill_reg == '0)
                    req_status = ST_EMPTY;
                else
                    rem_ok = 1'b1;
            end
            ACT_DELETE:
            begin
                if (fill_reg == '0)
                    req_status = ST_EMPTY;
                else if (position == '0 || CMP_W'(position) > CMP_W'(fill_reg))
                    req_status = ST_BADPOS;
                else
                    rem_ok = 1'b1;
            end
            default:
            begin
                req_status = ST_OK;
            end
        endcase
    end

    assign rm_idx = (act_reg == ACT_DELETE) ? ADDR_W'(pos_reg - POS_W'(1)) : '0;

    always_comb
    begin
        if (cmd.rd_removed)
            raddr = rm_idx;
        else if (cmd.shift_rd)
            raddr = ptr_reg + ADDR_W'(1);
        else
            raddr = scan_ptr_reg[ADDR_W-1:0];
    end

    assign we    = cmd.push_wr | cmd.shift_wr;
    assign waddr = cmd.push_wr ? fill_reg[ADDR_W-1:0] : ptr_reg;
    assign wdata = cmd.push_wr ? val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign stat.push_ok    = push_ok_reg;
    assign stat.rem_ok     = rem_ok_reg;
    assign stat.shift_more = (CNT_W'(ptr_reg) + CNT_W'(1)) < fill_reg;
    assign stat.scan_more  = scan_ptr_reg < fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            scan_pv_reg <= 1'b0;
            first_reg   <= 1'b1;
        end
        else
        begin
            if (cmd.push_wr)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (cmd.dec_fill)
                fill_reg <= fill_reg - CNT_W'(1);

            scan_pv_reg <= cmd.scan_rd;

            if (cmd.scan_start)
                first_reg <= 1'b1;
            else if (scan_pv_reg)
                first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg        <= action;
            val_reg        <= push_value;
            pos_reg        <= position;
            req_status_reg <= req_status;
            push_ok_reg    <= push_ok;
            rem_ok_reg     <= rem_ok;
            removed_reg    <= '0;
        end
        if (cmd.rd_removed)
            ptr_reg <= rm_idx;
        else if (cmd.shift_wr)
            ptr_reg <= ptr_reg + ADDR_W'(1);
        if (cmd.cap_removed)
            removed_reg <= rdata_reg;

        if (cmd.scan_start)
        begin
            scan_ptr_reg <= '0;
            max_reg      <= '0;
        end
        else
        begin
            if (cmd.scan_rd)
                scan_ptr_reg <= scan_ptr_reg + CNT_W'(1);
            // compare the beat read on the previous cycle
            if (scan_pv_reg && (first_reg || rdata_reg > max_reg))
                max_reg <= rdata_reg;
        end

        if (cmd.out_load)
        begin
            status_reg      <= req_status_reg;
            out_value_reg   <= removed_reg;
            entry_count_reg <= COUNT_W'(fill_reg);
            max_out_reg     <= max_reg;
        end
    end

    assign status      = status_reg;
    assign out_value   = out_value_reg;
    assign entry_count = entry_count_reg;
    assign max_value   = max_out_reg;

endmodule

// ----- hdl/fqdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// fqdm_ctrl
// Sequencer: request decode, removal and gap shift, maximum scan, result
// hand-off.
// ----------------------------------------------------------------------------
module fqdm_ctrl
    import fqdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CAPTURE,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_SCAN_INIT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.push_ok)
                begin
                    cmd.push_wr = 1'b1;
                    state_next  = S_SCAN_INIT;
                end
                else if (stat.rem_ok)
                begin
                    cmd.rd_removed = 1'b1;
                    state_next     = S_CAPTURE;
                end
                else
                begin
                    state_next = S_SCAN_INIT;
                end
            end
            S_CAPTURE:
            begin
                cmd.cap_removed = 1'b1;
                state_next      = S_SHIFT_CHK;
            end
            S_SHIFT_CHK:
            begin
                if (stat.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    cmd.dec_fill = 1'b1;
                    state_next   = S_SCAN_INIT;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_SCAN_INIT:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                // last compare lands on the edge that leaves this state
                if (stat.scan_more)
                    cmd.scan_rd = 1'b1;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/fifo_queue_delete_max_top.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_delete_max_top
// Bounded FIFO of signed 32-bit values with push, pop, delete-at-position,
// reporting status, count and maximum of the stored values per request.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   action, push_value, position
//   out      output     out_valid / out_ready status, out_value, entry_count,
//                                             max_value
//
// One request at a time. A push writes the tail; a pop or delete reads the
// removed entry and shifts each entry behind it down one place to close the
// gap. Every request, no-op and refused ones too, ends with a scan of the
// stored entries for the maximum. The store has one read port: each shift
// step and each scan step is a read.
// Reset clears the count and control; stored entries are not cleared.
// A result held on a stalled out channel blocks only the next hand-off.
// ----------------------------------------------------------------------------
module fifo_queue_delete_max_top
    import fqdm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [DATA_W-1:0]  push_value,
    input  logic [POS_W-1:0]          position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic signed [DATA_W-1:0]  out_value,
    output logic [COUNT_W-1:0]        entry_count,
    output logic signed [DATA_W-1:0]  max_value
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fqdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fqdm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .push_value  (push_value),
        .position    (position),
        .status      (status),
        .out_value   (out_value),
        .entry_count (entry_count),
        .max_value   (max_value)
    );

endmodule
